@@ rtl/banked_flash_command_emulator_macros.svh @@
// Assertion macros used by the flash command emulator controller.
`ifndef BANKED_FLASH_COMMAND_EMULATOR_MACROS_SVH
`define BANKED_FLASH_COMMAND_EMULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define BFCE_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define BFCE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/bfce_pkg.sv @@
// Shared constants, types and controller/datapath interface structs.
package bfce_pkg;

	// Geometry
	localparam int BANK_BYTES   = 65536;
	localparam int SECTOR_BYTES = 4096;
	localparam int BANK_COUNT   = 2;
	localparam int ADDR_W       = $clog2(BANK_BYTES);
	localparam int SEC_W        = $clog2(SECTOR_BYTES);
	localparam int BANK_W       = $clog2(BANK_COUNT);
	localparam int MEM_AW       = BANK_W + ADDR_W;
	localparam int MEM_DEPTH    = BANK_COUNT * BANK_BYTES;

	// Stream payload widths
	localparam int DATA_W      = 8;
	localparam int ADDR_IN_W   = 16;
	localparam int S_TDATA_W   = 24;
	localparam int M_TDATA_W   = 8;

	// Configuration port
	localparam int APB_DW = 32;
	localparam int CFG_AW = 3;
	localparam int CFG_IW = CFG_AW - 2;
	localparam logic [CFG_IW-1:0] REG_MAKER_ID = CFG_IW'(0);
	localparam logic [CFG_IW-1:0] REG_PART_ID  = CFG_IW'(1);

	// Access kinds on tuser
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Bus addresses and bytes of the unlock sequence
	localparam logic [ADDR_W-1:0] ADDR_CMD     = ADDR_W'(16'h5555);
	localparam logic [ADDR_W-1:0] ADDR_UNLOCK2 = ADDR_W'(16'h2AAA);
	localparam logic [ADDR_W-1:0] ADDR_MAKER   = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_PART    = ADDR_W'(1);
	localparam logic [DATA_W-1:0] UNLOCK_BYTE1 = 8'hAA;
	localparam logic [DATA_W-1:0] UNLOCK_BYTE2 = 8'h55;
	localparam logic [DATA_W-1:0] ERASED_BYTE  = 8'hFF;

	// Command opcodes
	localparam logic [DATA_W-1:0] OPC_ID_ON        = 8'h90;
	localparam logic [DATA_W-1:0] OPC_ID_OFF       = 8'hF0;
	localparam logic [DATA_W-1:0] OPC_ARM_ERASE    = 8'h80;
	localparam logic [DATA_W-1:0] OPC_CHIP_ERASE   = 8'h10;
	localparam logic [DATA_W-1:0] OPC_SECTOR_ERASE = 8'h30;
	localparam logic [DATA_W-1:0] OPC_BYTE_WRITE   = 8'hA0;
	localparam logic [DATA_W-1:0] OPC_BANK_SEL     = 8'hB0;

	typedef enum logic [2:0] {
		CMD_OTHER,
		CMD_ID_ON,
		CMD_ID_OFF,
		CMD_ARM_ERASE,
		CMD_CHIP_ERASE,
		CMD_BYTE_WRITE,
		CMD_BANK_SEL
	} cmd_t;

	// Command sequence phase
	typedef enum logic [2:0] {
		PH_UNLOCK1 = 3'd0,
		PH_UNLOCK2 = 3'd1,
		PH_COMMAND = 3'd2,
		PH_DATA    = 3'd3,
		PH_BANK    = 3'd4
	} phase_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP,
		ST_WRITE,
		ST_SWEEP
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic              in_ready;
		logic              out_load;
		logic              mem_write;
		logic              sweep_init;
		logic              sweep_chip;
		logic              sweep_step;
		logic [BANK_W-1:0] bank;
		logic              id_mode;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic              new_read;
		logic              addr_cmd;
		logic              addr_unlock2;
		logic              sector_aligned;
		logic              data_unlock1;
		logic              data_unlock2;
		logic              data_sector;
		cmd_t              cmd;
		logic              bank_ok;
		logic [BANK_W-1:0] new_bank;
		logic              out_free;
		logic              sweep_last;
	} dp_status_t;

endpackage

@@ rtl/bfce_datapath.sv @@
// Datapath: request register, flash memory, erase sweep counter, result register.
module bfce_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic [bfce_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	input  logic                          m_tready,
	output logic                          m_tvalid,
	output logic [bfce_pkg::M_TDATA_W-1:0] m_tdata,
	input  logic [bfce_pkg::DATA_W-1:0]    maker_id,
	input  logic [bfce_pkg::DATA_W-1:0]    part_id,
	input  bfce_pkg::dp_cmd_t              cmd,
	output bfce_pkg::dp_status_t           status
);
	import bfce_pkg::*;

	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] data_q;
	logic [DATA_W-1:0] flash_mem_q [0:MEM_DEPTH-1];
	logic [DATA_W-1:0] rd_data_q;
	logic [MEM_AW-1:0] sweep_q;
	logic              sweep_chip_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic [MEM_AW-1:0] acc_addr;
	logic              mem_we;
	logic [MEM_AW-1:0] mem_wa;
	logic [DATA_W-1:0] mem_wd;
	logic [DATA_W-1:0] out_data;
	cmd_t              cmd_code;

	// Request register, address masked to the bank size
	always_ff @(posedge clk) begin
		if (s_tvalid && cmd.in_ready) begin
			addr_q <= s_tdata[ADDR_W-1:0];
			data_q <= s_tdata[ADDR_IN_W +: DATA_W];
		end
	end

	assign acc_addr = {cmd.bank, addr_q};

	// Single write port: erase sweep or byte program
	assign mem_we = cmd.sweep_step || cmd.mem_write;
	assign mem_wa = cmd.sweep_step ? sweep_q : acc_addr;
	assign mem_wd = cmd.sweep_step ? ERASED_BYTE : data_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flash_mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= flash_mem_q[acc_addr];
	end

	// Erase sweep pointer; after reset it clears the whole chip
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= '0;
			sweep_chip_q <= 1'b1;
		end else if (cmd.sweep_init) begin
			sweep_q      <= cmd.sweep_chip ? '0 : acc_addr;
			sweep_chip_q <= cmd.sweep_chip;
		end else if (cmd.sweep_step) begin
			sweep_q <= sweep_q + MEM_AW'(1);
		end
	end

	// ID bytes override the array at the two lowest offsets
	always_comb begin
		if (cmd.id_mode && addr_q == ADDR_MAKER) begin
			out_data = maker_id;
		end else if (cmd.id_mode && addr_q == ADDR_PART) begin
			out_data = part_id;
		end else begin
			out_data = rd_data_q;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= out_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Command byte decode
	always_comb begin
		case (data_q)
			OPC_ID_ON:      cmd_code = CMD_ID_ON;
			OPC_ID_OFF:     cmd_code = CMD_ID_OFF;
			OPC_ARM_ERASE:  cmd_code = CMD_ARM_ERASE;
			OPC_CHIP_ERASE: cmd_code = CMD_CHIP_ERASE;
			OPC_BYTE_WRITE: cmd_code = CMD_BYTE_WRITE;
			OPC_BANK_SEL:   cmd_code = CMD_BANK_SEL;
			default:        cmd_code = CMD_OTHER;
		endcase
	end

	// Status to the controller
	always_comb begin
		status.new_read       = (s_tuser == OP_READ);
		status.addr_cmd       = (addr_q == ADDR_CMD);
		status.addr_unlock2   = (addr_q == ADDR_UNLOCK2);
		status.sector_aligned = (addr_q[SEC_W-1:0] == '0);
		status.data_unlock1   = (data_q == UNLOCK_BYTE1);
		status.data_unlock2   = (data_q == UNLOCK_BYTE2);
		status.data_sector    = (data_q == OPC_SECTOR_ERASE);
		status.cmd            = cmd_code;
		status.bank_ok        = (32'(data_q) < BANK_COUNT);
		status.new_bank       = data_q[BANK_W-1:0];
		status.out_free       = !m_tvalid_q || m_tready;
		status.sweep_last     = sweep_chip_q ? (&sweep_q) : (&sweep_q[SEC_W-1:0]);
	end

endmodule

@@ rtl/bfce_ctrl.sv @@
// Controller: access sequencing, command phase machine, ID mode and bank select.
`include "banked_flash_command_emulator_macros.svh"

module bfce_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  bfce_pkg::dp_status_t status,
	output bfce_pkg::dp_cmd_t    cmd
);
	import bfce_pkg::*;

	state_t            state_q;
	state_t            state_d;
	phase_t            phase_q;
	phase_t            phase_d;
	logic              id_mode_q;
	logic              id_mode_d;
	logic [BANK_W-1:0] bank_q;
	logic [BANK_W-1:0] bank_d;
	logic              go_sector;
	logic              go_chip;
	logic              byte_wr;

	// Decode of a write request against the current phase
	always_comb begin
		phase_d   = PH_UNLOCK1;
		id_mode_d = id_mode_q;
		bank_d    = bank_q;
		go_sector = 1'b0;
		go_chip   = 1'b0;
		byte_wr   = 1'b0;
		case (phase_q)
			PH_UNLOCK2: begin
				if (status.data_unlock2 && status.addr_unlock2) begin
					phase_d = PH_COMMAND;
				end
			end
			PH_COMMAND: begin
				if (status.addr_cmd && !status.data_sector) begin
					case (status.cmd)
						CMD_ID_ON:      id_mode_d = 1'b1;
						CMD_ID_OFF:     id_mode_d = 1'b0;
						CMD_ARM_ERASE:  phase_d = PH_UNLOCK1;
						CMD_CHIP_ERASE: go_chip = 1'b1;
						CMD_BYTE_WRITE: phase_d = PH_DATA;
						CMD_BANK_SEL:   phase_d = PH_BANK;
						default:        phase_d = PH_COMMAND;
					endcase
				end else if (status.data_sector && status.sector_aligned) begin
					go_sector = 1'b1;
				end
			end
			PH_DATA: begin
				byte_wr = 1'b1;
			end
			PH_BANK: begin
				if (status.bank_ok) begin
					bank_d = status.new_bank;
				end
			end
			default: begin
				if (status.data_unlock1 && status.addr_cmd) begin
					phase_d = PH_UNLOCK2;
				end
			end
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = status.new_read ? ST_READ : ST_WRITE;
				end
			end
			ST_READ: state_d = ST_RESP;
			ST_RESP: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_WRITE: state_d = (go_sector || go_chip) ? ST_SWEEP : ST_IDLE;
			ST_SWEEP: begin
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs to the datapath
	always_comb begin
		cmd.in_ready   = (state_q == ST_IDLE);
		cmd.out_load   = (state_q == ST_RESP) && status.out_free;
		cmd.mem_write  = (state_q == ST_WRITE) && byte_wr;
		cmd.sweep_init = (state_q == ST_WRITE) && (go_sector || go_chip);
		cmd.sweep_chip = go_chip;
		cmd.sweep_step = (state_q == ST_SWEEP);
		cmd.bank       = bank_q;
		cmd.id_mode    = id_mode_q;
	end

	// State and command registers; reset starts with the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_SWEEP;
			phase_q   <= PH_UNLOCK1;
			id_mode_q <= 1'b0;
			bank_q    <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_WRITE) begin
				phase_q   <= phase_d;
				id_mode_q <= id_mode_d;
				bank_q    <= bank_d;
			end
		end
	end

	`BFCE_ASSERT_NEXT(a_accept_dispatch, clk, arst_n, (state_q == ST_IDLE && s_tvalid), (state_q == ST_READ || state_q == ST_WRITE), "accepted request not dispatched")
	`BFCE_ASSERT_NEXT(a_data_phase_ends, clk, arst_n, (state_q == ST_WRITE && phase_q == PH_DATA), (phase_q == PH_UNLOCK1), "byte program did not close the sequence")
	`BFCE_ASSERT(a_sweep_from_command, clk, arst_n, (state_q == ST_WRITE && state_d == ST_SWEEP), (phase_q == PH_COMMAND), "erase started outside the command phase")
	`BFCE_ASSERT_NEXT(a_resp_holds, clk, arst_n, (state_q == ST_RESP && !status.out_free), (state_q == ST_RESP), "read result dropped while output busy")

endmodule

@@ rtl/banked_flash_command_emulator.sv @@
// Top level: two-bank byte flash command emulator with APB ID registers.
//
// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  tuser op; tdata address, write_data
// m_*       out  m_tvalid/m_tready  tdata read_data
// APB       in   psel/penable       maker_id at 0x0, part_id at 0x4
//
// A read passes through the read and response states; its result is registered in the
// response state, after the registered memory read port. A write passes through the
// write state. Sector and chip erase add a sweep of the sector or the whole chip: the
// single write port of the byte-wide flash memory is swept one byte per cycle. After
// reset the same whole-chip clearing sweep runs before the first request is taken;
// APB writes are taken throughout. A stalled result holds the read in ST_RESP.
module banked_flash_command_emulator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [bfce_pkg::S_TDATA_W-1:0] s_tdata,  // address[15:0], write_data[23:16]
	input  logic                           s_tuser,  // op[0]
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [bfce_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfce_pkg::CFG_AW-1:0]    paddr,
	input  logic [bfce_pkg::APB_DW-1:0]    pwdata,
	output logic [bfce_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);
	import bfce_pkg::*;

	logic [DATA_W-1:0] maker_id_q;
	logic [DATA_W-1:0] part_id_q;
	logic [CFG_IW-1:0] reg_idx;
	logic              cfg_we;
	dp_cmd_t           dp_cmd;
	dp_status_t        dp_status;

	// APB register file
	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_we  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			maker_id_q <= '0;
			part_id_q  <= '0;
		end else if (cfg_we) begin
			case (reg_idx)
				REG_MAKER_ID: maker_id_q <= pwdata[DATA_W-1:0];
				REG_PART_ID:  part_id_q  <= pwdata[DATA_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MAKER_ID: prdata = APB_DW'(maker_id_q);
			REG_PART_ID:  prdata = APB_DW'(part_id_q);
			default:      prdata = '0;
		endcase
	end

	assign s_tready = dp_cmd.in_ready;

	bfce_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.status   (dp_status),
		.cmd      (dp_cmd)
	);

	bfce_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.maker_id (maker_id_q),
		.part_id  (part_id_q),
		.cmd      (dp_cmd),
		.status   (dp_status)
	);

endmodule

@@ tb/sv/banked_flash_command_emulator_checker.sv @@
// Checker for the flash command emulator: predicts read bytes and compares them with the result stream.
`timescale 1ns / 100ps
module banked_flash_command_emulator_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [bfce_pkg::S_TDATA_W-1:0] s_tdata,  // address[15:0], write_data[23:16]
	input  logic                           s_tuser,  // op[0]
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [bfce_pkg::M_TDATA_W-1:0] m_tdata,  // read_data[7:0]
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bfce_pkg::CFG_AW-1:0]    paddr,
	input  logic [bfce_pkg::APB_DW-1:0]    pwdata,
	input  logic                           pready,
	output int                             mismatches,
	output int                             owed_reads,
	output int                             reads_compared
);
	import bfce_pkg::*;

	typedef struct {
		logic [ADDR_IN_W-1:0] address;
		logic [DATA_W-1:0]    read_data;
	} owed_read_t;

	// Shadow of the flash contents and the command machine
	logic [DATA_W-1:0] flash_image [MEM_DEPTH];
	logic [BANK_W-1:0] active_bank;
	phase_t            seq_phase;
	logic              id_shown;
	logic [DATA_W-1:0] maker_byte;
	logic [DATA_W-1:0] part_byte;
	owed_read_t        owed_q [$];

	// Set a run of bytes back to the erased value
	task automatic erase_range(input int first, input int count);
		for (int i = 0; i < count; i++)
			flash_image[first + i] = ERASED_BYTE;
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		owed_read_t        owed;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] wbyte;
		if (!arst_n) begin
			erase_range(0, MEM_DEPTH);
			active_bank = '0;
			seq_phase = PH_UNLOCK1;
			id_shown = 1'b0;
			maker_byte = '0;
			part_byte = '0;
			owed_q.delete();
			mismatches = 0;
			owed_reads = 0;
			reads_compared = 0;
		end else begin
			// ID register writes
			if (psel && penable && pwrite && pready) begin
				if (paddr[CFG_AW-1:2] == REG_MAKER_ID)
					maker_byte = pwdata[DATA_W-1:0];
				else if (paddr[CFG_AW-1:2] == REG_PART_ID)
					part_byte = pwdata[DATA_W-1:0];
			end

			// Returned bytes against the oldest predicted read
			if (m_tvalid && m_tready) begin
				if (owed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: read result %02h with no read outstanding",
							$realtime, m_tdata);
				end else begin
					owed = owed_q.pop_front();
					reads_compared++;
					if (m_tdata !== owed.read_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: read_data at %04h: expected %02h, got %02h",
								$realtime, owed.address, owed.read_data, m_tdata);
					end
				end
			end

			// Accepted request: reads are predicted, writes step the command machine
			if (s_tvalid && s_tready) begin
				addr = s_tdata[ADDR_W-1:0];
				wbyte = s_tdata[ADDR_IN_W +: DATA_W];
				if (s_tuser == OP_READ) begin
					owed.address = addr;
					if (id_shown && addr == ADDR_MAKER)
						owed.read_data = maker_byte;
					else if (id_shown && addr == ADDR_PART)
						owed.read_data = part_byte;
					else
						owed.read_data = flash_image[{active_bank, addr}];
					owed_q.push_back(owed);
				end else begin
					case (seq_phase)
					PH_UNLOCK2:
						seq_phase = (wbyte == UNLOCK_BYTE2 && addr == ADDR_UNLOCK2) ?
							PH_COMMAND : PH_UNLOCK1;
					PH_COMMAND: begin
						if (addr == ADDR_CMD && wbyte != OPC_SECTOR_ERASE) begin
							case (wbyte)
							OPC_ID_ON: begin
								id_shown = 1'b1;
								seq_phase = PH_UNLOCK1;
							end
							OPC_ID_OFF: begin
								id_shown = 1'b0;
								seq_phase = PH_UNLOCK1;
							end
							OPC_ARM_ERASE:
								seq_phase = PH_UNLOCK1;
							OPC_CHIP_ERASE: begin
								erase_range(0, MEM_DEPTH);
								seq_phase = PH_UNLOCK1;
							end
							OPC_BYTE_WRITE:
								seq_phase = PH_DATA;
							OPC_BANK_SEL:
								seq_phase = PH_BANK;
							// unknown opcode: still waiting for a command
							default: ;
							endcase
						end else if (wbyte == OPC_SECTOR_ERASE && addr[SEC_W-1:0] == '0) begin
							erase_range(int'({active_bank, addr}), SECTOR_BYTES);
							seq_phase = PH_UNLOCK1;
						end else begin
							seq_phase = PH_UNLOCK1;
						end
					end
					PH_DATA: begin
						flash_image[{active_bank, addr}] = wbyte;
						seq_phase = PH_UNLOCK1;
					end
					PH_BANK: begin
						// out-of-range bank numbers are dropped
						if (wbyte < DATA_W'(BANK_COUNT))
							active_bank = wbyte[BANK_W-1:0];
						seq_phase = PH_UNLOCK1;
					end
					default:
						seq_phase = (wbyte == UNLOCK_BYTE1 && addr == ADDR_CMD) ?
							PH_UNLOCK2 : PH_UNLOCK1;
					endcase
				end
			end
			owed_reads = owed_q.size();
		end
	end

endmodule

@@ tb/sv/banked_flash_command_emulator_tb.sv @@
// Testbench top for the flash command emulator: clock, reset, bus stimulus and verdict.
`timescale 1ns / 100ps
module banked_flash_command_emulator_tb;
	import bfce_pkg::*;

	localparam int RANDOM_ITEMS      = 2000;
	localparam int PHASES            = 4;
	localparam int MAX_SECTOR_ERASES = 40;
	localparam int MAX_CHIP_ERASES   = 3;
	// Slowest pass: clearing sweep, three chip erases, 40 sector erases, about 2100
	// requests with gaps and stalls.
	localparam int RUN_LIMIT = 4_000_000;

	localparam logic [DATA_W-1:0] OPC_UNKNOWN = 8'h00;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;  // address[15:0], write_data[23:16]
	logic                 s_tuser;  // op[0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;  // read_data[7:0]
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [CFG_AW-1:0]    paddr;
	logic [APB_DW-1:0]    pwdata;
	logic [APB_DW-1:0]    prdata;
	logic                 pready;

	int mismatches;
	int owed_reads;
	int reads_compared;

	int burst_left;
	int requests_sent;
	int sector_erases;
	int chip_erases;
	int settings_used;
	int cycle_count = 0;
	int stall_mode = 0;
	int stall_left = 0;
	logic [ADDR_IN_W-1:0] hot_addr [16];

	banked_flash_command_emulator dut (.*);

	banked_flash_command_emulator_checker flash_check (.*);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// Result stream back-pressure: ready, random, or mostly stalled, in stretches
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(0, 2);
			stall_left <= $urandom_range(32, 256);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
		0: m_tready <= 1'b1;
		1: m_tready <= 1'($urandom_range(0, 1));
		default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// One bus request; bursts of random length separated by random gaps
	task automatic send_request(input logic op, input logic [ADDR_IN_W-1:0] addr,
		input logic [DATA_W-1:0] wbyte);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) :
				$urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {wbyte, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		requests_sent++;
	endtask

	task automatic unlock_seq();
		send_request(OP_WRITE, ADDR_CMD, UNLOCK_BYTE1);
		send_request(OP_WRITE, ADDR_UNLOCK2, UNLOCK_BYTE2);
	endtask

	task automatic issue_command(input logic [DATA_W-1:0] opc);
		unlock_seq();
		send_request(OP_WRITE, ADDR_CMD, opc);
	endtask

	// Setup then access phase, then back to idle
	task automatic apb_write(input logic [CFG_IW-1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [ADDR_IN_W-1:0] pick_address();
		if ($urandom_range(0, 9) < 7)
			return hot_addr[$urandom_range(0, 15)];
		return ADDR_IN_W'($urandom);
	endfunction

	// Closing read drains any erase in flight; then wait for every read to return
	task automatic settle();
		send_request(OP_READ, pick_address(), DATA_W'($urandom));
		s_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (owed_reads != 0);
		repeat (8) @(posedge clk);
	endtask

	initial begin : stimulus
		int                   sel;
		int                   directed_end;
		logic [DATA_W-1:0]    opc;
		logic [ADDR_IN_W-1:0] a;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= OP_READ;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		burst_left = 0;
		requests_sent = 0;
		sector_erases = 0;
		chip_erases = 0;
		// addresses that reads and writes keep returning to
		hot_addr[0] = ADDR_MAKER;
		hot_addr[1] = ADDR_PART;
		hot_addr[2] = 16'hFFFF;
		hot_addr[3] = ADDR_CMD;
		hot_addr[4] = ADDR_UNLOCK2;
		hot_addr[5] = 16'h0FFF;
		hot_addr[6] = 16'h1000;
		for (int i = 7; i < 16; i++)
			hot_addr[i] = ADDR_IN_W'($urandom);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_write(REG_MAKER_ID, 8'hFF);
		apb_write(REG_PART_ID, 8'h00);
		settings_used = 1;

		// Directed: broken unlocks, unknown opcode, every command, edge addresses
		send_request(OP_WRITE, ADDR_CMD, UNLOCK_BYTE2);
		send_request(OP_WRITE, ADDR_CMD, UNLOCK_BYTE1);
		send_request(OP_WRITE, ADDR_UNLOCK2 + 16'd1, UNLOCK_BYTE2);
		issue_command(OPC_UNKNOWN);
		send_request(OP_WRITE, ADDR_CMD, OPC_BYTE_WRITE);
		send_request(OP_WRITE, 16'hFFFF, 8'h00);
		send_request(OP_READ, 16'hFFFF, 8'hFF);
		issue_command(OPC_ID_ON);
		send_request(OP_READ, ADDR_MAKER, 8'h00);
		send_request(OP_READ, ADDR_PART, 8'h00);
		issue_command(OPC_BANK_SEL);
		send_request(OP_WRITE, 16'h0000, DATA_W'(BANK_COUNT));
		issue_command(OPC_ARM_ERASE);
		unlock_seq();
		send_request(OP_WRITE, 16'hF000, OPC_SECTOR_ERASE);
		sector_erases++;
		send_request(OP_READ, 16'hFFFF, 8'h00);
		issue_command(OPC_CHIP_ERASE);
		chip_erases++;
		issue_command(OPC_ID_OFF);
		directed_end = requests_sent;

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				settle();
				case (phase)
				1: begin
					apb_write(REG_MAKER_ID, 8'h00);
					apb_write(REG_PART_ID, 8'hFF);
				end
				2: begin
					apb_write(REG_MAKER_ID, DATA_W'($urandom));
					apb_write(REG_PART_ID, DATA_W'($urandom));
				end
				default: begin
					apb_write(REG_MAKER_ID, 8'h00);
					apb_write(REG_PART_ID, 8'h00);
				end
				endcase
				settings_used++;
			end

			// Mostly complete command sequences with random content, some noise
			while (requests_sent < directed_end + (phase + 1) * RANDOM_ITEMS / PHASES) begin
				sel = $urandom_range(0, 99);
				if (sel < 35) begin
					send_request(OP_READ, pick_address(), DATA_W'($urandom));
				end else if (sel < 62) begin
					issue_command(OPC_BYTE_WRITE);
					send_request(OP_WRITE, pick_address(), DATA_W'($urandom));
				end else if (sel < 68) begin
					issue_command($urandom_range(0, 1) ? OPC_ID_ON : OPC_ID_OFF);
				end else if (sel < 74) begin
					issue_command(OPC_BANK_SEL);
					send_request(OP_WRITE, pick_address(), ($urandom_range(0, 3) == 0) ?
						DATA_W'($urandom) : DATA_W'($urandom_range(0, BANK_COUNT - 1)));
				end else if (sel < 76) begin
					issue_command(OPC_ARM_ERASE);
				end else if (sel < 78 && sector_erases < MAX_SECTOR_ERASES) begin
					unlock_seq();
					if ($urandom_range(0, 3) != 0) begin
						a = ADDR_IN_W'($urandom_range(0, BANK_BYTES / SECTOR_BYTES - 1) *
							SECTOR_BYTES);
						sector_erases++;
					end else begin
						a = ADDR_IN_W'($urandom);
						if (a[SEC_W-1:0] == '0)
							a[0] = 1'b1;
					end
					send_request(OP_WRITE, a, OPC_SECTOR_ERASE);
				end else if (sel == 78 && chip_erases < MAX_CHIP_ERASES &&
					$urandom_range(0, 3) == 0) begin
					issue_command(OPC_CHIP_ERASE);
					chip_erases++;
				end else begin
					// noise and broken sequences
					case ($urandom_range(0, 3))
					0: send_request(OP_WRITE, ADDR_IN_W'($urandom), DATA_W'($urandom));
					1: begin
						send_request(OP_WRITE, ADDR_CMD, UNLOCK_BYTE1);
						send_request(OP_WRITE, pick_address(), DATA_W'($urandom));
					end
					2: begin
						opc = DATA_W'($urandom);
						if (opc == OPC_CHIP_ERASE)
							opc = OPC_UNKNOWN;
						issue_command(opc);
					end
					default: begin
						unlock_seq();
						opc = DATA_W'($urandom);
						if (opc == OPC_CHIP_ERASE)
							opc = OPC_UNKNOWN;
						send_request(OP_WRITE, pick_address(), opc);
					end
					endcase
				end
			end
		end
		settle();

		$display("Run covered %0d bus requests with %0d reads compared, %0d sector erases,",
			requests_sent, reads_compared, sector_erases);
		$display("%0d chip erases and %0d ID register settings; %0d errors, %0d reads owed.",
			chip_erases, settings_used, mismatches, owed_reads);
		if (mismatches == 0 && owed_reads == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
